// ----- sv/sgmg_pkg.sv -----
// ----------------------------------------------------------------------------
// sgmg_pkg
// Shared types and constants for the smart-grid mode governor.
// ----------------------------------------------------------------------------
package sgmg_pkg;

	localparam int TimeW   = 32;
	localparam int TempW   = 16;
	localparam int PriceW  = 3;
	localparam int CountW  = 4;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 32;
	localparam int InDatW  = 56;  // 51 field bits, padded to whole bytes
	localparam int OutDatW = 16;  // 11 field bits, padded to whole bytes

	localparam logic [CountW-1:0] CountMax = '1;

	// Tariff levels; anything above high is unknown and treated as normal
	localparam logic [PriceW-1:0] PriceVeryLow = 3'd0;
	localparam logic [PriceW-1:0] PriceLow     = 3'd1;
	localparam logic [PriceW-1:0] PriceNormal  = 3'd2;
	localparam logic [PriceW-1:0] PriceHigh    = 3'd3;

	typedef enum logic [1:0] {
		MODE_BLOCKED    = 2'd0,
		MODE_NORMAL     = 2'd1,
		MODE_ENCOURAGED = 2'd2,
		MODE_ORDERED    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OUT_DISABLED  = 3'd0,
		OUT_HELD      = 3'd1,
		OUT_UNCHANGED = 3'd2,
		OUT_CHANGED   = 3'd3,
		OUT_NEWDAY    = 3'd4
	} outcome_t;

	typedef enum logic [0:0] {
		OP_EVALUATE = 1'b0,
		OP_NEWDAY   = 1'b1
	} opcode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ENABLE      = 3'd0,
		REG_ALLOW_ORD   = 3'd1,
		REG_ALLOW_ENC   = 3'd2,
		REG_MIN_TEMP    = 3'd3,
		REG_HOLD_OFF    = 3'd4,
		REG_MIN_BLOCKED = 3'd5,
		REG_MAX_BLOCKED = 3'd6,
		REG_QUOTA       = 3'd7
	} reg_idx_t;

	// Reset values of the configuration registers
	localparam logic              RstEnable     = 1'b1;
	localparam logic signed [TempW-1:0] RstMinTemp = 16'sd272; // 17.0 degC
	localparam logic [TimeW-1:0]  RstHoldOff    = 32'd599000;
	localparam logic [TimeW-1:0]  RstMinBlocked = 32'd3600000;
	localparam logic [TimeW-1:0]  RstMaxBlocked = 32'd7200000;
	localparam logic [CountW-1:0] RstQuota      = 4'd3;

	typedef struct packed {
		logic                     enable;
		logic                     allow_ordered;
		logic                     allow_encouraged;
		logic signed [TempW-1:0]  min_temperature;
		logic [TimeW-1:0]         hold_off_ms;
		logic [TimeW-1:0]         min_blocked_ms;
		logic [TimeW-1:0]         max_blocked_ms;
		logic [CountW-1:0]        daily_block_quota;
	} cfg_t;

	typedef struct packed {
		opcode_t                 opcode;
		logic [TimeW-1:0]        now_ms;
		logic [PriceW-1:0]       tariff_level;
		logic signed [TempW-1:0] temperature;
	} item_t;

	typedef struct packed {
		mode_t             mode;
		logic              relay_a_drive;
		logic              relay_b_drive;
		outcome_t          outcome;
		logic [CountW-1:0] blocked_sessions;
	} result_t;

endpackage

// ----- sv/smart_grid_mode_governor.sv -----
// ----------------------------------------------------------------------------
// smart_grid_mode_governor
// Heat-pump grid mode governor with inverted relay outputs.
// ----------------------------------------------------------------------------
// Takes one item per clock when the output side keeps up. An item is captured
// in the input register, decided in a single pass against the governor state
// (mode, time of last change, blocked session count), and its result lands
// in the output register, which drives m_tvalid and m_tdata.
// Throughput is one transfer per cycle; it is set only by the output
// handshake, since each register advances whenever the one after it is free
// or being emptied. Configuration writes are always accepted (cfg_ready is
// tied high) and should be issued only while no item is in flight.
// Opcode rides in s_tuser: 0 evaluates the mode, 1 starts a new day.
// ----------------------------------------------------------------------------
module smart_grid_mode_governor
	import sgmg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [InDatW-1:0]  s_tdata,  // [31:0] now_ms, [34:32] tariff_level,
	                                     // [50:35] temperature, [55:51] zero
	input  logic [0:0]         s_tuser,  // [0] opcode
	// result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OutDatW-1:0] m_tdata,  // [1:0] mode, [2] relay_a_drive,
	                                     // [3] relay_b_drive, [6:4] outcome,
	                                     // [10:7] blocked_sessions, [15:11] zero
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgDatW-1:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    adv_s2;    // output register takes a new result
	logic    adv_s1;    // input register takes a new item

	assign cfg_ready = 1'b1;

	sgmg_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// output register is free when empty or draining this cycle
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			item_s1.opcode       <= opcode_t'(s_tuser[0]);
			item_s1.now_ms       <= s_tdata[31:0];
			item_s1.tariff_level <= s_tdata[34:32];
			item_s1.temperature  <= s_tdata[50:35];
		end
	end

	// decision pass; state updates only when the result moves on
	sgmg_decide u_decide (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.commit (valid_s1 && adv_s2),
		.result (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, res_s2.blocked_sessions, res_s2.outcome,
		res_s2.relay_b_drive, res_s2.relay_a_drive, res_s2.mode};

endmodule

// ----- sv/sgmg_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sgmg_cfg_regs
// Configuration register file, one write per transfer, always ready.
// ----------------------------------------------------------------------------
module sgmg_cfg_regs
	import sgmg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [CfgIdxW-1:0] wr_index,
	input  logic [CfgDatW-1:0] wr_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable            <= RstEnable;
			cfg_q.allow_ordered     <= 1'b0;
			cfg_q.allow_encouraged  <= 1'b0;
			cfg_q.min_temperature   <= RstMinTemp;
			cfg_q.hold_off_ms       <= RstHoldOff;
			cfg_q.min_blocked_ms    <= RstMinBlocked;
			cfg_q.max_blocked_ms    <= RstMaxBlocked;
			cfg_q.daily_block_quota <= RstQuota;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_ENABLE:      cfg_q.enable            <= wr_data[0];
				REG_ALLOW_ORD:   cfg_q.allow_ordered     <= wr_data[0];
				REG_ALLOW_ENC:   cfg_q.allow_encouraged  <= wr_data[0];
				REG_MIN_TEMP:    cfg_q.min_temperature   <= wr_data[TempW-1:0];
				REG_HOLD_OFF:    cfg_q.hold_off_ms       <= wr_data[TimeW-1:0];
				REG_MIN_BLOCKED: cfg_q.min_blocked_ms    <= wr_data[TimeW-1:0];
				REG_MAX_BLOCKED: cfg_q.max_blocked_ms    <= wr_data[TimeW-1:0];
				REG_QUOTA:       cfg_q.daily_block_quota <= wr_data[CountW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/sgmg_decide.sv -----
// ----------------------------------------------------------------------------
// sgmg_decide
// Mode decision logic and governor state (mode, last change time, count).
// ----------------------------------------------------------------------------
module sgmg_decide
	import sgmg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    commit,   // item leaves the input register this cycle
	output result_t result
);

	mode_t             mode_q;
	logic [TimeW-1:0]  last_change_q;
	logic [CountW-1:0] count_q;

	mode_t             wanted;
	mode_t             mode_nx;
	logic [TimeW-1:0]  last_nx;
	logic [CountW-1:0] count_nx;
	logic [CountW-1:0] count_inc;
	logic [TimeW-1:0]  elapsed;
	logic              held;
	logic              change;
	outcome_t          outcome;

	assign elapsed   = item.now_ms - last_change_q;
	assign held      = (item.now_ms != '0) && (elapsed < cfg.hold_off_ms);
	assign count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;

	always_comb begin
		case (item.tariff_level)
			PriceVeryLow: wanted = cfg.allow_ordered ? MODE_ORDERED :
				cfg.allow_encouraged ? MODE_ENCOURAGED : MODE_NORMAL;
			PriceLow: wanted = cfg.allow_encouraged ? MODE_ENCOURAGED : MODE_NORMAL;
			PriceHigh: wanted = (count_q < cfg.daily_block_quota &&
				item.temperature >= cfg.min_temperature) ? MODE_BLOCKED : MODE_NORMAL;
			default: wanted = MODE_NORMAL;
		endcase
	end

	always_comb begin
		mode_nx  = mode_q;
		last_nx  = last_change_q;
		count_nx = count_q;
		change   = 1'b0;
		if (item.opcode == OP_NEWDAY) begin
			count_nx = '0;
			outcome  = OUT_NEWDAY;
		end else if (!cfg.enable) begin
			mode_nx = MODE_NORMAL;
			outcome = OUT_DISABLED;
		end else begin
			if (held) begin
				outcome = OUT_HELD;
			end else if (mode_q == MODE_BLOCKED) begin
				// leaving blocked needs the minimum; staying is cut at the maximum
				if (wanted != MODE_BLOCKED) begin
					change = elapsed >= cfg.min_blocked_ms;
				end else begin
					change = elapsed >= cfg.max_blocked_ms;
				end
				if (change) begin
					count_nx = count_inc;
				end
				outcome = change ? OUT_CHANGED : OUT_UNCHANGED;
			end else if (wanted == mode_q) begin
				outcome = OUT_UNCHANGED;
			end else begin
				change  = 1'b1;
				outcome = OUT_CHANGED;
			end
			if (change) begin
				// a forced end of a blocked session wants blocked again: go normal
				mode_nx = (mode_q == MODE_BLOCKED && wanted == MODE_BLOCKED) ?
					MODE_NORMAL : wanted;
				last_nx = item.now_ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_NORMAL;
			last_change_q <= '0;
			count_q       <= '0;
		end else if (commit) begin
			mode_q        <= mode_nx;
			last_change_q <= last_nx;
			count_q       <= count_nx;
		end
	end

	assign result.mode             = mode_nx;
	assign result.relay_a_drive    = !(mode_nx == MODE_BLOCKED || mode_nx == MODE_ORDERED);
	assign result.relay_b_drive    = !(mode_nx == MODE_ENCOURAGED || mode_nx == MODE_ORDERED);
	assign result.outcome          = outcome;
	assign result.blocked_sessions = count_nx;

endmodule

// ----- sim/smart_grid_mode_governor_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smart_grid_mode_governor_test
// Self-checking bench for the grid mode governor. A queue of evaluate and
// new-day items feeds a bursty stream driver. A behavioral predictor tracks
// mode, time of last change and session count for every accepted transfer.
// A monitor under a shifting stall pattern checks each result field by field.
// A directed opening covers the rule paths, then randomized phases follow,
// each under a fresh register set.
// ----------------------------------------------------------------------------
module smart_grid_mode_governor_test
	import sgmg_pkg::*;
;

	localparam int PhaseCount  = 10;
	localparam int PhaseItems  = 125;
	localparam int DrainCycles = 4;     // pipeline is two deep, leave margin
	localparam int QuietLimit  = 4000;  // cycles with no transfer of any kind

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [InDatW-1:0]  s_tdata = '0;  // now_ms, tariff_level, temperature, zero pad
	logic [0:0]         s_tuser = '0;  // opcode
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OutDatW-1:0] m_tdata;       // mode, relay_a, relay_b, outcome, sessions, pad
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDatW-1:0] cfg_data = '0;

	smart_grid_mode_governor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Register shadow, updated on each config transfer
	// ------------------------------------------------------------------
	logic                    cfg_en      = RstEnable;
	logic                    cfg_ord     = 1'b0;
	logic                    cfg_enc     = 1'b0;
	logic signed [TempW-1:0] cfg_floor   = RstMinTemp;
	logic [TimeW-1:0]        cfg_hold    = RstHoldOff;
	logic [TimeW-1:0]        cfg_min_blk = RstMinBlocked;
	logic [TimeW-1:0]        cfg_max_blk = RstMaxBlocked;
	logic [CountW-1:0]       cfg_quota   = RstQuota;

	// Governor state as the predictor sees it
	mode_t             gov_mode     = MODE_NORMAL;
	logic [TimeW-1:0]  gov_stamp    = '0;
	logic [CountW-1:0] gov_sessions = '0;

	item_t   pending_items[$];
	result_t awaited_results[$];
	int      mismatches = 0;

	function automatic void apply_reg(reg_idx_t idx, logic [CfgDatW-1:0] data);
		case (idx)
			REG_ENABLE:      cfg_en      = data[0];
			REG_ALLOW_ORD:   cfg_ord     = data[0];
			REG_ALLOW_ENC:   cfg_enc     = data[0];
			REG_MIN_TEMP:    cfg_floor   = data[TempW-1:0];
			REG_HOLD_OFF:    cfg_hold    = data;
			REG_MIN_BLOCKED: cfg_min_blk = data;
			REG_MAX_BLOCKED: cfg_max_blk = data;
			REG_QUOTA:       cfg_quota   = data[CountW-1:0];
			default: ;
		endcase
	endfunction

	// Mode the tariff asks for, before timing rules are applied
	function automatic mode_t preferred_mode(logic [PriceW-1:0] price,
			logic signed [TempW-1:0] temp);
		case (price)
			PriceVeryLow: begin
				if (cfg_ord)
					return MODE_ORDERED;
				if (cfg_enc)
					return MODE_ENCOURAGED;
				return MODE_NORMAL;
			end
			PriceLow:  return cfg_enc ? MODE_ENCOURAGED : MODE_NORMAL;
			// blocking needs quota left and a warm enough house
			PriceHigh: return (gov_sessions < cfg_quota && temp >= cfg_floor) ?
					MODE_BLOCKED : MODE_NORMAL;
			default:   return MODE_NORMAL;  // normal and unknown levels
		endcase
	endfunction

	// Advances the governor state by one item and returns its result
	function automatic result_t decide_mode(item_t it);
		result_t          r;
		mode_t            target;
		logic [TimeW-1:0] elapsed;
		logic             switch_now;
		outcome_t         oc;
		switch_now = 1'b0;
		if (it.opcode == OP_NEWDAY) begin
			gov_sessions = '0;
			oc = OUT_NEWDAY;
		end else if (!cfg_en) begin
			gov_mode = MODE_NORMAL;
			oc = OUT_DISABLED;
		end else begin
			elapsed = it.now_ms - gov_stamp;  // wraps mod 2^32
			target = preferred_mode(it.tariff_level, it.temperature);
			if (it.now_ms != '0 && elapsed < cfg_hold) begin
				oc = OUT_HELD;
			end else if (gov_mode == MODE_BLOCKED) begin
				if (target != MODE_BLOCKED) begin
					// may leave only after the minimum session
					switch_now = elapsed >= cfg_min_blk;
				end else begin
					// session cut short at the maximum, timer kept otherwise
					switch_now = elapsed >= cfg_max_blk;
					target = MODE_NORMAL;
				end
				if (switch_now && gov_sessions != CountMax)
					gov_sessions = gov_sessions + 1'b1;
				oc = switch_now ? OUT_CHANGED : OUT_UNCHANGED;
			end else if (target == gov_mode) begin
				oc = OUT_UNCHANGED;
			end else begin
				switch_now = 1'b1;
				oc = OUT_CHANGED;
			end
			if (switch_now) begin
				gov_mode = target;
				gov_stamp = it.now_ms;
			end
		end
		r.mode             = gov_mode;
		r.relay_a_drive    = !(gov_mode == MODE_BLOCKED || gov_mode == MODE_ORDERED);
		r.relay_b_drive    = !(gov_mode == MODE_ENCOURAGED || gov_mode == MODE_ORDERED);
		r.outcome          = oc;
		r.blocked_sessions = gov_sessions;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Input driver: bursts of random length separated by random gaps
	// ------------------------------------------------------------------
	item_t shown_item;
	item_t load_item;
	logic  load_valid;
	int    burst_left = 1;
	int    gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				awaited_results.push_back(decide_mode(shown_item));
			if (!s_tvalid || s_tready) begin
				load_valid = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_items.size() != 0) begin
					load_item = pending_items.pop_front();
					load_valid = 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						// a quarter of the bursts run back to back
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end
				s_tvalid <= load_valid;
				if (load_valid) begin
					shown_item = load_item;
					s_tdata <= {{(InDatW-TimeW-PriceW-TempW){1'b0}},
							load_item.temperature, load_item.tariff_level, load_item.now_ms};
					s_tuser <= load_item.opcode;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor with a receiver stall pattern that changes style
	// ------------------------------------------------------------------
	result_t due;
	int      stall_tick = 0;
	int      stall_style = 0;
	logic    take_next;

	function automatic void check_field(string name, int unsigned expd, int unsigned got);
		if (expd != got) begin
			$error("%s: expected %0d, got %0d", name, expd, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					$error("result transfer with no expectation waiting");
					mismatches++;
				end else begin
					due = awaited_results.pop_front();
					check_field("mode", due.mode, m_tdata[1:0]);
					check_field("relay_a_drive", due.relay_a_drive, m_tdata[2]);
					check_field("relay_b_drive", due.relay_b_drive, m_tdata[3]);
					check_field("outcome", due.outcome, m_tdata[6:4]);
					check_field("blocked_sessions", due.blocked_sessions, m_tdata[10:7]);
				end
			end
			stall_tick++;
			if (stall_tick % 97 == 0)
				stall_style = $urandom_range(0, 3);
			case (stall_style)
				0:       take_next = 1'b1;                   // always ready
				1:       take_next = (stall_tick % 3) != 0;  // one in three stalled
				2:       take_next = $urandom_range(0, 1);   // coin toss
				default: take_next = (stall_tick % 16) < 8;  // long stalls
			endcase
			m_tready <= take_next;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: ends a run that stops moving
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic void add_item(opcode_t op, logic [TimeW-1:0] now,
			logic [PriceW-1:0] price, logic signed [TempW-1:0] temp);
		item_t it;
		it.opcode       = op;
		it.now_ms       = now;
		it.tariff_level = price;
		it.temperature  = temp;
		pending_items.push_back(it);
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [CfgDatW-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	// Block is idle once every result is in and the last item has left;
	// sampled on the falling edge so the driver's updates have settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || awaited_results.size() != 0 || s_tvalid);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Time steps aimed at the hold-off, minimum and maximum windows
	function automatic logic [TimeW-1:0] next_now(logic [TimeW-1:0] t);
		logic [TimeW-1:0] stride;
		case ($urandom_range(0, 9))
			0:       return '0;  // time zero bypasses the hold-off
			1:       return $urandom();
			2, 3:    stride = $urandom_range(0, cfg_hold);
			4, 5:    stride = $urandom_range(cfg_hold, cfg_min_blk);
			6, 7:    stride = $urandom_range(cfg_min_blk, cfg_max_blk);
			8:       stride = cfg_max_blk + $urandom_range(0, 1000);
			default: stride = cfg_hold + $urandom_range(0, 16);
		endcase
		return t + stride;
	endfunction

	// Temperature at or above the blocking floor
	function automatic logic signed [TempW-1:0] warm_temp();
		int lo;
		lo = cfg_floor;
		return TempW'(lo + int'($urandom_range(0, 32767 - lo)));
	endfunction

	task automatic program_phase(int phase);
		logic [TimeW-1:0]        hold, min_b, max_b;
		logic signed [TempW-1:0] floor_t;
		logic [CountW-1:0]       quota;
		int                      style;
		style = (phase == 0) ? 2 : (phase == 1) ? 3 : $urandom_range(0, 4);
		case (style)
			0: begin  // field-like timing
				hold  = RstHoldOff;
				min_b = RstMinBlocked;
				max_b = RstMaxBlocked;
			end
			1: begin  // short windows so sessions turn over quickly
				hold  = $urandom_range(0, 200);
				min_b = hold + $urandom_range(0, 400);
				max_b = min_b + $urandom_range(0, 800);
			end
			2: begin
				hold  = '0;
				min_b = '0;
				max_b = '0;
			end
			3: begin
				hold  = '1;
				min_b = '1;
				max_b = '1;
			end
			default: begin
				hold  = $urandom();
				min_b = $urandom();
				max_b = $urandom();
			end
		endcase
		floor_t = (phase == 0) ? 16'sh8000 : (phase == 1) ? 16'sh7fff :
				($urandom_range(0, 1) != 0) ? RstMinTemp : TempW'($urandom());
		quota = (phase == 0) ? 4'd15 : (phase == 1) ? 4'd0 : CountW'($urandom_range(0, 15));
		write_reg(REG_ENABLE, (phase == 2) ? 1'b0 : ($urandom_range(0, 9) != 0));
		write_reg(REG_ALLOW_ORD, $urandom_range(0, 1));
		write_reg(REG_ALLOW_ENC, $urandom_range(0, 1));
		write_reg(REG_MIN_TEMP, CfgDatW'(floor_t));
		write_reg(REG_HOLD_OFF, hold);
		write_reg(REG_MIN_BLOCKED, min_b);
		write_reg(REG_MAX_BLOCKED, max_b);
		write_reg(REG_QUOTA, quota);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [TimeW-1:0]        clock_ms;
		logic [PriceW-1:0]       price;
		logic signed [TempW-1:0] temp;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset register values: walk through a blocked session's life
		add_item(OP_EVALUATE, 32'd0, PriceHigh, 16'sd272);          // time zero, enters blocked
		add_item(OP_EVALUATE, 32'd1000, PriceNormal, 16'sd0);       // inside hold-off
		add_item(OP_EVALUATE, 32'd1000000, PriceNormal, 16'sd0);    // ending too soon
		add_item(OP_EVALUATE, 32'd3599999, 3'd4, 16'sd0);           // unknown price, still early
		add_item(OP_EVALUATE, 32'd3600000, PriceHigh, 16'sd300);    // stays blocked below max
		add_item(OP_EVALUATE, 32'd3600000, PriceLow, 16'sd0);       // ends in time
		add_item(OP_EVALUATE, 32'd4300000, PriceHigh, 16'sd271);    // just under the floor
		add_item(OP_EVALUATE, 32'd4300000, PriceHigh, 16'sd272);    // on the floor
		add_item(OP_EVALUATE, 32'd11500000, PriceHigh, 16'sh7fff);  // forced out at max
		add_item(OP_EVALUATE, 32'd12200000, PriceHigh, 16'sd1000);
		add_item(OP_EVALUATE, 32'd19400000, 3'd7, 16'sd0);
		add_item(OP_EVALUATE, 32'd20000000, PriceHigh, 16'sh7fff);  // quota spent
		add_item(OP_NEWDAY, 32'd20000001, 3'd7, 16'sh8000);
		add_item(OP_EVALUATE, 32'd21000000, PriceHigh, 16'sh8000);  // coldest reading
		add_item(OP_EVALUATE, 32'hffff_ffff, PriceVeryLow, 16'sd0);
		wait_drained();

		// Both allow switches on: ordered and encouraged modes
		write_reg(REG_ALLOW_ORD, 1'b1);
		write_reg(REG_ALLOW_ENC, 1'b1);
		@(negedge clk);
		add_item(OP_EVALUATE, 32'd100, PriceVeryLow, 16'sd0);      // timer wrapped around
		add_item(OP_EVALUATE, 32'd200, PriceLow, 16'sd0);
		add_item(OP_EVALUATE, 32'd700000, PriceLow, 16'sd0);
		add_item(OP_EVALUATE, 32'd1400000, PriceVeryLow, 16'sd0);
		wait_drained();

		// Governor switched off
		write_reg(REG_ENABLE, 1'b0);
		@(negedge clk);
		add_item(OP_EVALUATE, 32'd1500000, PriceHigh, 16'sd1000);
		add_item(OP_NEWDAY, 32'd1500001, PriceNormal, 16'sd0);
		wait_drained();

		// Random phases, a fresh register set each
		clock_ms = $urandom();
		for (int phase = 0; phase < PhaseCount; phase++) begin
			program_phase(phase);
			@(negedge clk);
			for (int n = 0; n < PhaseItems; n++) begin
				clock_ms = next_now(clock_ms);
				if ($urandom_range(0, 24) == 0) begin
					add_item(OP_NEWDAY, clock_ms, PriceW'($urandom()), TempW'($urandom()));
				end else begin
					// high price dominates so blocked sessions start often
					price = ($urandom_range(0, 9) < 4) ? PriceHigh : PriceW'($urandom_range(0, 7));
					temp = ($urandom_range(0, 4) != 0) ? warm_temp() : TempW'($urandom());
					add_item(OP_EVALUATE, clock_ms, price, temp);
				end
			end
			wait_drained();
		end

		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
